@@ rtl/core/adpcm_pkg.sv @@
// Shared types and constants for the 4-bit ADPCM frame decoder.
package adpcm_pkg;

    localparam int NUM_PAIRS   = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int PAIR_SEL_W  = 3;
    localparam int SHIFT_W     = 4;
    localparam int POS_W       = 3;
    localparam int SAMPLE_W    = 16;
    localparam int ACC_W       = 34;
    localparam int FRAC_BITS   = 11;

    localparam logic [POS_W-1:0] POS_HEADER   = 3'd0;
    localparam logic [POS_W-1:0] POS_LAST     = 3'd7;
    localparam logic             CMD_FRAME    = 1'b0;
    localparam logic             CMD_LOAD     = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;
    localparam logic signed [ACC_W-1:0]    ROUND_HALF = 34'sd1024;

    // One operation handed from the front to the back.
    // For a history load, pair holds {history_newer, history_older}.
    typedef struct packed {
        logic                  is_load;
        logic                  frame_end;
        logic [SHIFT_W-1:0]    shift;
        logic [7:0]            data_byte;
        logic [CFG_DATA_W-1:0] pair;
    } queue_op_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

    typedef enum logic {
        BK_HIGH,
        BK_LOW
    } back_state_t;

endpackage

@@ rtl/core/adpcm_front.sv @@
// Front end: coefficient registers, frame position tracking, op classification.
module adpcm_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  adpcm_pkg::cfg_wr_t                    cfg_wr,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_command,
    input  logic [7:0]                            in_data_byte,
    input  logic [adpcm_pkg::SAMPLE_W-1:0]        in_hist_newer,
    input  logic [adpcm_pkg::SAMPLE_W-1:0]        in_hist_older,
    output logic                                  push_valid,
    input  logic                                  push_ready,
    output adpcm_pkg::queue_op_t                  push_op
);

    logic [adpcm_pkg::CFG_DATA_W-1:0] coef_reg [adpcm_pkg::NUM_PAIRS];
    logic [adpcm_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [adpcm_pkg::PAIR_SEL_W-1:0] sel_reg, sel_next;
    logic [adpcm_pkg::SHIFT_W-1:0]    shift_reg, shift_next;
    logic                             accept;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < adpcm_pkg::NUM_PAIRS; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_wr.valid &&
                     cfg_wr.index < adpcm_pkg::CFG_INDEX_W'(adpcm_pkg::NUM_PAIRS)) begin
            coef_reg[cfg_wr.index[adpcm_pkg::PAIR_SEL_W-1:0]] <= cfg_wr.data;
        end
    end

    always_comb begin
        pos_next   = pos_reg;
        sel_next   = sel_reg;
        shift_next = shift_reg;
        push_valid = 1'b0;
        push_op.is_load   = 1'b0;
        push_op.frame_end = (pos_reg == adpcm_pkg::POS_LAST);
        push_op.shift     = shift_reg;
        push_op.data_byte = in_data_byte;
        push_op.pair      = coef_reg[sel_reg];
        if (in_command == adpcm_pkg::CMD_LOAD) begin
            push_valid      = in_valid;
            push_op.is_load = 1'b1;
            push_op.pair    = {in_hist_newer, in_hist_older};
            if (accept) pos_next = adpcm_pkg::POS_HEADER;
        end else if (pos_reg == adpcm_pkg::POS_HEADER) begin
            // header: latch predictor and shift, nothing for the back end
            if (accept) begin
                sel_next   = in_data_byte[6:4];
                shift_next = in_data_byte[3:0];
                pos_next   = adpcm_pkg::POS_W'(1);
            end
        end else begin
            push_valid = in_valid;
            if (accept) begin
                pos_next = (pos_reg == adpcm_pkg::POS_LAST) ? adpcm_pkg::POS_HEADER
                                                            : pos_reg + adpcm_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= adpcm_pkg::POS_HEADER;
            sel_reg   <= '0;
            shift_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            sel_reg   <= sel_next;
            shift_reg <= shift_next;
        end
    end

endmodule

@@ rtl/core/adpcm_queue.sv @@
// Small register queue between the front and back ends.
module adpcm_queue #(
    parameter int DEPTH = adpcm_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  adpcm_pkg::queue_op_t push_op,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output adpcm_pkg::queue_op_t pop_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    adpcm_pkg::queue_op_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push) cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/core/adpcm_back.sv @@
// Back end: history, sample datapath, nibble sequencer and output register.
module adpcm_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   op_valid,
    output logic                                   op_pop,
    input  adpcm_pkg::queue_op_t                   op,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic signed [adpcm_pkg::SAMPLE_W-1:0]  m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tuser
);

    localparam int ACC_W = adpcm_pkg::ACC_W;
    localparam int SW    = adpcm_pkg::SAMPLE_W;
    localparam int Q_W   = ACC_W - adpcm_pkg::FRAC_BITS;

    adpcm_pkg::back_state_t state_reg, state_next;
    logic signed [SW-1:0]   newer_reg, older_reg;
    logic                   out_valid_reg;
    logic signed [SW-1:0]   out_data_reg;
    logic                   out_last_reg, out_end_reg;

    logic                   out_free, out_load;
    logic [3:0]             nib;
    logic signed [ACC_W-1:0] nib_ext, scaled, acc;
    logic signed [SW-1:0]   c1, c2;
    logic signed [2*SW-1:0] p1, p2;
    logic signed [Q_W-1:0]  q;
    logic signed [SW-1:0]   sample;

    assign out_free = !out_valid_reg || m_tready;
    assign out_load = op_valid && !op.is_load && out_free;

    // Datapath: one sample per cycle while out_free; history feeds back.
    assign nib     = (state_reg == adpcm_pkg::BK_LOW) ? op.data_byte[3:0] : op.data_byte[7:4];
    assign nib_ext = {{(ACC_W-4){nib[3]}}, nib};
    assign scaled  = nib_ext <<< ({1'b0, op.shift} + 5'(adpcm_pkg::FRAC_BITS));
    assign c1      = op.pair[2*SW-1:SW];
    assign c2      = op.pair[SW-1:0];
    assign p1      = c1 * newer_reg;
    assign p2      = c2 * older_reg;
    assign acc     = scaled + adpcm_pkg::ROUND_HALF + ACC_W'(p1) + ACC_W'(p2);
    assign q       = acc[ACC_W-1:adpcm_pkg::FRAC_BITS];

    always_comb begin
        if (q > Q_W'(adpcm_pkg::SAMPLE_MAX)) sample = adpcm_pkg::SAMPLE_MAX;
        else if (q < Q_W'(adpcm_pkg::SAMPLE_MIN)) sample = adpcm_pkg::SAMPLE_MIN;
        else sample = q[SW-1:0];
    end

    // High nibble, then low nibble; a load pops without an output sample.
    always_comb begin
        state_next = state_reg;
        op_pop     = 1'b0;
        case (state_reg)
            adpcm_pkg::BK_HIGH: begin
                if (op_valid && op.is_load) op_pop = 1'b1;
                else if (out_load) state_next = adpcm_pkg::BK_LOW;
            end
            adpcm_pkg::BK_LOW: begin
                if (out_load) begin
                    op_pop     = 1'b1;
                    state_next = adpcm_pkg::BK_HIGH;
                end
            end
            default: state_next = adpcm_pkg::BK_HIGH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= adpcm_pkg::BK_HIGH;
            newer_reg     <= '0;
            older_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (op_valid && op.is_load) begin
                newer_reg <= op.pair[2*SW-1:SW];
                older_reg <= op.pair[SW-1:0];
            end else if (out_load) begin
                newer_reg <= sample;
                older_reg <= newer_reg;
            end
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= sample;
            out_last_reg <= (state_reg == adpcm_pkg::BK_LOW);
            out_end_reg  <= (state_reg == adpcm_pkg::BK_LOW) && op.frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

`ifndef NO_ASSERTIONS
    a_low_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == adpcm_pkg::BK_LOW) |-> (op_valid && !op.is_load))
        else $error("low-nibble phase without a data op at queue head");

    a_data_pop_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_pop && !op.is_load) |-> (state_reg == adpcm_pkg::BK_LOW))
        else $error("data op popped before its second sample");

    a_low_sets_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && state_reg == adpcm_pkg::BK_LOW) |=> (m_tvalid && m_tlast))
        else $error("second sample of a byte not marked last");

    a_end_with_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end flagged on a high-nibble sample");
`endif

endmodule

@@ rtl/core/adpcm_4bit_frame_decoder.sv @@
// Top level of the 4-bit ADPCM frame decoder.
// Decodes 8-byte ADPCM frames fed one byte per input transfer. The first byte of
// a frame is a header (bits 6..4 pick one of eight Q11 coefficient pairs, bits
// 3..0 the scale shift) and gives no output; each of the seven data bytes gives
// two 16-bit samples, high nibble first. A transfer with s_tuser set loads the
// two history samples from s_tdata and restarts at a header. A data byte is
// decoded one sample after the other, because each sample feeds the next
// through the history multiply-accumulate in the back end. The front end keeps
// accepting transfers into a QUEUE_DEPTH-entry queue while the back end works
// and while a finished sample waits in the output register.
// Coefficient pairs are written through the cfg port (index 0..7, writes to
// other indexes are ignored) and should be written only while the decoder is
// idle; cfg_ready is always high.
module adpcm_4bit_frame_decoder #(
    parameter int QUEUE_DEPTH = adpcm_pkg::QUEUE_DEPTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [adpcm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [adpcm_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [39:0]                           s_tdata,  // data_byte[7:0], history_newer[23:8], history_older[39:24]
    input  logic                                  s_tuser,  // command
    // output stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic signed [adpcm_pkg::SAMPLE_W-1:0] m_tdata,  // pcm_sample[15:0]
    output logic                                  m_tlast,  // last_of_run
    output logic                                  m_tuser   // frame_end
);

    adpcm_pkg::cfg_wr_t    cfg_wr;
    adpcm_pkg::queue_op_t  push_op, pop_op;
    logic                  push_valid, push_ready;
    logic                  pop_valid, pop_ready;

    // Config writes never stall.
    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    // Front: classifies each transfer as header, data byte or history load.
    adpcm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr        (cfg_wr),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_command    (s_tuser),
        .in_data_byte  (s_tdata[7:0]),
        .in_hist_newer (s_tdata[23:8]),
        .in_hist_older (s_tdata[39:24]),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_op       (push_op)
    );

    // Decoupling queue: front and back stall independently.
    adpcm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    // Back: two samples per data op, output register toward the sink.
    adpcm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (pop_valid),
        .op_pop   (pop_ready),
        .op       (pop_op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the 4-bit ADPCM frame decoder.
module testbench;
    import adpcm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on any channel
    localparam int DRAIN_CYCLES   = 16;    // settle time for headers and loads in flight
    localparam int LONG_HOLD      = 250;   // receiver hold-off to back the block up
    localparam int RANDOM_ITEMS   = 177;   // per random phase, three phases

    // coefficient register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_PAIR_0 = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = 8'd8;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP_UNUSED = 8'hFF;

    typedef struct packed {
        logic        cmd;
        logic [39:0] payload;  // history_older, history_newer, data_byte
    } byte_xfer_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;
    } coef_write_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pcm;
        logic                       run_last;
        logic                       frame_end;
    } pcm_result_t;

    // clock, reset and DUT ports; every input starts at a known value
    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [39:0]                s_tdata   = '0;
    logic                       s_tuser   = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic signed [SAMPLE_W-1:0] m_tdata;
    logic                       m_tlast;
    logic                       m_tuser;

    logic hold_pulse = 1'b0;  // one-cycle request for the long receiver hold-off

    // predictor state
    logic [CFG_DATA_W-1:0]      coef_table [NUM_PAIRS];
    logic signed [SAMPLE_W-1:0] hist_new;
    logic signed [SAMPLE_W-1:0] hist_old;
    logic [POS_W-1:0]           frame_pos;
    logic [PAIR_SEL_W-1:0]      pair_sel;
    logic [SHIFT_W-1:0]         shift_amt;

    byte_xfer_t  feed_q [$];
    coef_write_t coef_write_q [$];
    pcm_result_t pcm_expected_q [$];

    int n_fed, n_in, n_cfg_fed, n_cfg, n_out, n_frames, n_loads, err_count;
    int feed_gap, sink_stall, hold_left, idle_cycles;
    bit feed_bursty, sink_bursty;

    adpcm_4bit_frame_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Gap length: mostly none or short, now and then long; none at all in a burst.
    function automatic int pick_gap(input bit bursty);
        int r;
        r = $urandom_range(0, 99);
        if (bursty || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One decoded sample; shifts the history like the block does.
    function automatic logic signed [SAMPLE_W-1:0] next_sample(input logic [3:0] nib);
        logic [CFG_DATA_W-1:0]      pair;
        longint                     c1, c2, acc;
        logic signed [SAMPLE_W-1:0] s;
        pair = coef_table[pair_sel];
        c1   = longint'($signed(pair[31:16]));
        c2   = longint'($signed(pair[15:0]));
        acc  = longint'($signed(nib)) * (longint'(1) << shift_amt) * 2048;
        acc  = acc + longint'(ROUND_HALF) + c1 * longint'(hist_new) + c2 * longint'(hist_old);
        acc  = acc >>> FRAC_BITS;  // floor
        if (acc > longint'(SAMPLE_MAX)) s = SAMPLE_MAX;
        else if (acc < longint'(SAMPLE_MIN)) s = SAMPLE_MIN;
        else s = acc[SAMPLE_W-1:0];
        hist_old = hist_new;
        hist_new = s;
        return s;
    endfunction

    // Apply one accepted input transfer to the predictor and queue its samples.
    function automatic void decode_transfer(input logic cmd, input logic [39:0] d);
        logic                       at_end;
        logic signed [SAMPLE_W-1:0] s;
        if (cmd == CMD_LOAD) begin
            hist_new  = d[23:8];
            hist_old  = d[39:24];
            frame_pos = POS_HEADER;
            n_loads++;
        end else if (frame_pos == POS_HEADER) begin
            pair_sel  = d[6:4];   // bit 7 is don't-care
            shift_amt = d[3:0];
            frame_pos = frame_pos + POS_W'(1);
        end else begin
            at_end = (frame_pos == POS_LAST);
            s = next_sample(d[7:4]);
            pcm_expected_q.push_back('{s, 1'b0, 1'b0});
            s = next_sample(d[3:0]);
            pcm_expected_q.push_back('{s, 1'b1, at_end});
            frame_pos = at_end ? POS_HEADER : frame_pos + POS_W'(1);
        end
    endfunction

    // Input driver: offers queued items with random gaps.
    always @(posedge aclk) begin
        byte_xfer_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_transfer(s_tuser, s_tdata);
                n_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                    s_tvalid <= 1'b0;
                end else if (feed_q.size() > 0) begin
                    nxt = feed_q.pop_front();
                    s_tuser  <= nxt.cmd;
                    s_tdata  <= nxt.payload;
                    s_tvalid <= 1'b1;
                    feed_gap = pick_gap(feed_bursty);
                    if ($urandom_range(0, 19) == 0) feed_bursty = !feed_bursty;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Coefficient writes; the predictor table follows each accepted write.
    always @(posedge aclk) begin
        coef_write_t w;
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index < NUM_PAIRS) coef_table[cfg_index[PAIR_SEL_W-1:0]] = cfg_data;
                n_cfg++;
            end
            if (!cfg_valid || cfg_ready) begin
                if (coef_write_q.size() > 0) begin
                    w = coef_write_q.pop_front();
                    cfg_index <= w.index;
                    cfg_data  <= w.value;
                    cfg_valid <= 1'b1;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Sample monitor and checker; also owns the receiver stalls.
    always @(posedge aclk) begin
        pcm_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pcm_expected_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected sample: expected none, got pcm=%0d last=%0b end=%0b",
                             $time, m_tdata, m_tlast, m_tuser);
                end else begin
                    want = pcm_expected_q.pop_front();
                    n_out++;
                    if (want.frame_end) n_frames++;
                    if (m_tdata !== want.pcm) begin
                        err_count++;
                        $display("%0t: pcm_sample expected %0d got %0d", $time, want.pcm, m_tdata);
                    end
                    if (m_tlast !== want.run_last) begin
                        err_count++;
                        $display("%0t: last_of_run expected %0b got %0b",
                                 $time, want.run_last, m_tlast);
                    end
                    if (m_tuser !== want.frame_end) begin
                        err_count++;
                        $display("%0t: frame_end expected %0b got %0b",
                                 $time, want.frame_end, m_tuser);
                    end
                end
            end
            if (hold_pulse) hold_left = LONG_HOLD;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_stall = pick_gap(sink_bursty);
                if ($urandom_range(0, 19) == 0) sink_bursty = !sink_bursty;
            end
        end
    end

    // Watchdog: any transfer on any channel resets the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_item(input logic cmd, input logic [7:0] data_byte,
                             input logic [15:0] h_newer, input logic [15:0] h_older);
        feed_q.push_back('{cmd, {h_older, h_newer, data_byte}});
        n_fed++;
    endtask

    task automatic push_byte(input logic [7:0] data_byte);
        push_item(CMD_FRAME, data_byte, 16'($urandom), 16'($urandom));
    endtask

    task automatic push_load(input logic [15:0] h_newer, input logic [15:0] h_older);
        push_item(CMD_LOAD, 8'($urandom), h_newer, h_older);
    endtask

    task automatic push_coef(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        coef_write_q.push_back('{idx, v});
        n_cfg_fed++;
    endtask

    // Half the time a realistic Q11 pair, otherwise any 32-bit value.
    function automatic logic [CFG_DATA_W-1:0] random_coef();
        logic [15:0] c1, c2;
        if ($urandom_range(0, 1) == 0) return $urandom;
        c1 = 16'($signed($urandom_range(0, 8192)) - 4096);
        c2 = 16'($signed($urandom_range(0, 4096)) - 2048);
        return {c1, c2};
    endfunction

    // Header byte favoring small shifts; bit 7 random.
    function automatic logic [7:0] random_header();
        logic [3:0] sh;
        sh = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(0, 4)) : 4'($urandom);
        return {1'($urandom), 3'($urandom), sh};
    endfunction

    // Mostly whole frames with random content; some loads, some broken frames.
    task automatic queue_random_items(input int target);
        int added, brk, k;
        added = 0;
        while (added < target) begin
            if ($urandom_range(0, 99) < 6) begin
                push_load(16'($urandom), 16'($urandom));
                added++;
            end else begin
                brk = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 7) : 0;
                push_byte(random_header());
                added++;
                for (k = 1; k < 8; k++) begin
                    if (k == brk) begin
                        push_load(16'($urandom), 16'($urandom));
                        added++;
                        break;
                    end
                    push_byte(8'($urandom));
                    added++;
                end
            end
        end
    endtask

    // Sender pause: all items and writes taken, all samples back, block settled.
    task automatic wait_idle();
        while (n_in != n_fed || n_cfg != n_cfg_fed || pcm_expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int i;
        for (i = 0; i < NUM_PAIRS; i++) coef_table[i] = '0;
        hist_new  = '0;
        hist_old  = '0;
        frame_pos = POS_HEADER;
        pair_sel  = '0;
        shift_amt = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // extreme coefficient pairs, plus writes to unused indexes
        push_coef(REG_COEF_PAIR_0 + CFG_INDEX_W'(0), 32'h7FFF_8000);
        push_coef(REG_COEF_PAIR_0 + CFG_INDEX_W'(1), 32'h8000_7FFF);
        push_coef(REG_COEF_PAIR_0 + CFG_INDEX_W'(2), 32'h0800_0000);
        push_coef(REG_COEF_PAIR_0 + CFG_INDEX_W'(3), 32'hFFFF_FFFF);
        push_coef(REG_COEF_PAIR_0 + CFG_INDEX_W'(4), 32'h0000_0000);
        push_coef(REG_COEF_PAIR_0 + CFG_INDEX_W'(5), 32'h0FFF_F800);
        push_coef(REG_COEF_PAIR_0 + CFG_INDEX_W'(6), random_coef());
        push_coef(REG_COEF_PAIR_0 + CFG_INDEX_W'(7), 32'h8000_8000);
        push_coef(REG_FIRST_UNUSED, $urandom);
        push_coef(REG_TOP_UNUSED, $urandom);
        wait_idle();

        // directed: header with bit 7 and max shift, nibble extremes, full frame
        push_byte(8'h8F);
        push_byte(8'h07);
        push_byte(8'h80);
        push_byte(8'hF8);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h77);
        push_byte(8'h88);
        // history extremes, then a load in mid-frame
        push_load(16'h7FFF, 16'h8000);
        push_byte(8'h10);
        push_byte(8'h12);
        push_load(16'h8000, 16'h7FFF);
        push_byte(8'h70);
        push_byte(8'h9C);
        push_load(16'h0000, 16'h0000);
        push_byte(8'h3C);
        push_byte(8'h5A);
        push_load(16'hFFFF, 16'h0001);
        push_byte(8'h2B);
        push_byte(8'hE1);
        wait_idle();

        for (i = 0; i < NUM_PAIRS; i++)
            push_coef(REG_COEF_PAIR_0 + CFG_INDEX_W'(i), random_coef());
        wait_idle();

        // receiver holds off long while the sender keeps offering
        queue_random_items(RANDOM_ITEMS);
        @(posedge aclk);
        hold_pulse <= 1'b1;
        @(posedge aclk);
        hold_pulse <= 1'b0;
        wait_idle();

        for (i = 0; i < NUM_PAIRS; i++)
            push_coef(REG_COEF_PAIR_0 + CFG_INDEX_W'(i),
                      (i % 3 == 0) ? 32'h7FFF_7FFF :
                      (i % 3 == 1) ? 32'h8000_8000 : 32'h0000_0000);
        wait_idle();
        queue_random_items(RANDOM_ITEMS);
        wait_idle();

        for (i = 0; i < NUM_PAIRS; i++)
            push_coef(REG_COEF_PAIR_0 + CFG_INDEX_W'(i), random_coef());
        push_coef(8'($urandom_range(NUM_PAIRS, 255)), $urandom);
        wait_idle();
        queue_random_items(RANDOM_ITEMS);
        wait_idle();

        $display("covered %0d input transfers (%0d history loads), %0d coefficient writes",
                 n_in, n_loads, n_cfg);
        $display("checked %0d samples, %0d frame ends, %0d mismatches",
                 n_out, n_frames, err_count);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/adpcm_pkg.sv
rtl/core/adpcm_front.sv
rtl/core/adpcm_queue.sv
rtl/core/adpcm_back.sv
rtl/core/adpcm_4bit_frame_decoder.sv
test/testbench.sv
